// ===== design/pass_pkg.sv =====
// shared types, constants and sizes for the priority aware spread sketch
package pass_pkg;

    localparam int BITMAP_BITS   = 65536;
    localparam int BITMAP_HASHES = 2;
    localparam int CELL_COUNT    = 1024;
    localparam int SKETCH_ROWS   = 2;
    localparam int SKETCH_WIDTH  = 4096;
    localparam int MAX_LEVELS    = 64;

    localparam int BM_WORDS = BITMAP_BITS / 32;
    localparam int BM_AW    = $clog2(BM_WORDS);
    localparam int BM_IW    = $clog2(BITMAP_BITS);
    localparam int CELL_AW  = $clog2(CELL_COUNT);
    localparam int SK_CW    = $clog2(SKETCH_WIDTH);
    localparam int SK_RW    = (SKETCH_ROWS > 1) ? $clog2(SKETCH_ROWS) : 1;
    localparam int SK_AW    = SK_RW + SK_CW;
    localparam int SK_DEPTH = 1 << SK_AW;
    localparam int ROWC_W   = $clog2(SKETCH_ROWS + 1);
    localparam int CLR_W0   = (BM_AW > CELL_AW) ? BM_AW : CELL_AW;
    localparam int CLR_W    = (CLR_W0 > SK_AW) ? CLR_W0 : SK_AW;

    localparam int CNT_W = 24;
    localparam int LVL_W = 7;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [31:0] CELL_SEED_OFS = 32'd16;
    localparam logic [31:0] ROW_SEED_OFS  = 32'd96;

    localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2  = 32'h1b873593;
    localparam logic [31:0] MM_C3  = 32'h85ebca6b;
    localparam logic [31:0] MM_C4  = 32'hc2b2ae35;
    localparam logic [31:0] MM_ADD = 32'he6546b64;
    localparam logic [31:0] MM_LEN = 32'd4;

    localparam logic [1:0] CFG_LEVEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [1:0] CFG_SEED_BASE   = 2'd2;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic        start;
        logic [31:0] key;
        logic [31:0] seed;
    } hash_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BHASH,
        ST_BWAIT,
        ST_BREAD,
        ST_BCHK,
        ST_PTEST,
        ST_PHASH,
        ST_PWAIT,
        ST_PREAD,
        ST_PCHK,
        ST_PDEC,
        ST_SHASH,
        ST_SWAIT,
        ST_SREAD,
        ST_SCHK
    } state_t;

endpackage

// ===== design/pass_hash.sv =====
// iterative 32-bit murmur hash of one word over a single shared multiplier
module pass_hash (
    input  logic                clk,
    input  logic                rst_n,
    input  pass_pkg::hash_req_t req,
    output logic                done,
    output logic [31:0]         hash
);
    import pass_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] k_rot, h_rot, h_mix, h_add;

    assign mul_p = mul_a * mul_b;
    assign k_rot = {r_reg[16:0], r_reg[31:17]};
    assign h_rot = {h_mix[18:0], h_mix[31:19]};
    assign h_mix = seed_reg ^ r_reg;
    assign h_add = (((h_rot << 2) + h_rot) + MM_ADD) ^ MM_LEN;

    assign done = (step_reg == 3'd5);
    assign hash = r_reg ^ (r_reg >> 16);

    always_comb
    begin
        step_next = step_reg;
        r_next    = r_reg;
        seed_next = seed_reg;
        mul_a     = r_reg;
        mul_b     = MM_C3;
        unique case (step_reg)
            3'd0:
            begin
                mul_a = req.key;
                mul_b = MM_C1;
                if (req.start)
                begin
                    r_next    = mul_p;
                    seed_next = req.seed;
                    step_next = 3'd1;
                end
            end
            3'd1:
            begin
                mul_a     = k_rot;
                mul_b     = MM_C2;
                r_next    = mul_p;
                step_next = 3'd2;
            end
            3'd2:
            begin
                // mix into the seed and fold the high half down
                r_next    = h_add ^ (h_add >> 16);
                step_next = 3'd3;
            end
            3'd3:
            begin
                r_next    = mul_p;
                step_next = 3'd4;
            end
            3'd4:
            begin
                mul_a     = r_reg ^ (r_reg >> 13);
                mul_b     = MM_C4;
                r_next    = mul_p;
                step_next = 3'd5;
            end
            default:
            begin
                step_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= 3'd0;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        seed_reg <= seed_next;
    end

endmodule

// ===== design/priority_aware_spread_sketch_core.sv =====
// top level: sequencer, tables and configuration of the priority aware spread sketch
//
// After reset the block sweeps its tables clear (busy high), one entry of
// each table a cycle. An item is taken when start is high and busy low; its
// result shows for one cycle with done high and cannot be held off. Every
// step goes through one shared murmur hash unit followed by a table read: an
// update costs 2 bitmap probes, then (on a new pair) one probe per cell
// probed, up to level capped at 64, and one per sketch row if the sketch is
// touched; a query costs the cell probes and, when the source is not in a
// cell, the sketch rows. A repeated pair finishes after the bitmap probes.
module priority_aware_spread_sketch_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic [31:0]             source_label,
    input  logic [31:0]             dest_label,
    input  logic [pass_pkg::LVL_W-1:0] level,
    output logic                    done,
    output logic [pass_pkg::CNT_W-1:0] spread_estimate,
    output logic                    new_pair,
    output logic                    in_fine_part,
    output logic                    report,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data
);
    import pass_pkg::*;

    // configuration
    logic [LVL_W-1:0] level_count_reg;
    logic [CNT_W-1:0] threshold_reg;
    logic [31:0]      seed_base_reg;

    // sequencer
    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                cmd_reg, cmd_next;
    logic [31:0]         src_reg, src_next;
    logic [31:0]         dst_reg, dst_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [LVL_W-1:0]    probes_reg, probes_next;
    logic                high_reg, high_next;
    logic [LVL_W-1:0]    idx_reg, idx_next;
    logic [ROWC_W-1:0]   row_reg, row_next;
    logic                fresh_reg, fresh_next;
    logic                matched_reg, matched_next;
    logic                have_min_reg, have_min_next;
    logic [LVL_W-1:0]    min_lvl_reg, min_lvl_next;
    logic [CELL_AW-1:0]  min_idx_reg, min_idx_next;
    logic [31:0]         min_lab_reg, min_lab_next;
    logic [CNT_W-1:0]    min_cnt_reg, min_cnt_next;
    logic [CNT_W-1:0]    est_reg, est_next;
    logic                fine_reg, fine_next;
    logic                rep_reg, rep_next;
    logic [31:0]         sk_key_reg, sk_key_next;
    logic [CNT_W-1:0]    sk_amt_reg, sk_amt_next;
    logic                sk_min_reg, sk_min_next;
    logic [CNT_W-1:0]    best_reg, best_next;
    logic [BM_AW-1:0]    bm_addr_reg, bm_addr_next;
    logic [4:0]          bit_sel_reg, bit_sel_next;
    logic [CELL_AW-1:0]  cell_addr_reg, cell_addr_next;
    logic [SK_AW-1:0]    sk_addr_reg, sk_addr_next;
    logic                done_reg, done_next;

    // tables
    logic [31:0]      bm_mem [BM_WORDS];
    logic [31:0]      cell_lbl_mem [CELL_COUNT];
    logic [CNT_W-1:0] cell_cnt_mem [CELL_COUNT];
    logic [LVL_W-1:0] cell_lvl_mem [CELL_COUNT];
    logic [CNT_W-1:0] sk_mem [SK_DEPTH];

    logic [31:0]      bm_rd_reg;
    logic [31:0]      cell_lbl_rd_reg;
    logic [CNT_W-1:0] cell_cnt_rd_reg;
    logic [LVL_W-1:0] cell_lvl_rd_reg;
    logic [CNT_W-1:0] sk_rd_reg;

    logic             bm_we;
    logic [BM_AW-1:0] bm_wa;
    logic [31:0]      bm_wd;
    logic               cell_we_all, cell_we_cnt;
    logic [CELL_AW-1:0] cell_wa;
    logic [31:0]        cell_wd_lbl;
    logic [CNT_W-1:0]   cell_wd_cnt;
    logic [LVL_W-1:0]   cell_wd_lvl;
    logic             sk_we;
    logic [SK_AW-1:0] sk_wa;
    logic [CNT_W-1:0] sk_wd;

    // hash unit
    hash_req_t   hreq;
    logic        hdone;
    logic [31:0] hval;

    logic [31:0]      bit_mask;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W:0]   sk_sum;
    logic [CNT_W-1:0] sk_sat;
    logic [8:0]       lvl_x4, lc_x3;

    pass_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .done  (hdone),
        .hash  (hval)
    );

    assign bit_mask = 32'd1 << bit_sel_reg;
    assign cnt_inc  = (cell_cnt_rd_reg == COUNT_MAX) ? COUNT_MAX : cell_cnt_rd_reg + 1'b1;
    assign sk_sum   = {1'b0, sk_rd_reg} + {1'b0, sk_amt_reg};
    assign sk_sat   = sk_sum[CNT_W] ? COUNT_MAX : sk_sum[CNT_W-1:0];
    assign lvl_x4   = {level, 2'b00};
    assign lc_x3    = {1'b0, level_count_reg, 1'b0} + {2'b00, level_count_reg};

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign spread_estimate = est_reg;
    assign new_pair        = fresh_reg;
    assign in_fine_part    = fine_reg;
    assign report          = rep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= 7'd16;
            threshold_reg   <= 24'd1000;
            seed_base_reg   <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEVEL_COUNT: level_count_reg <= cfg_data[LVL_W-1:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[CNT_W-1:0];
                CFG_SEED_BASE:   seed_base_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cmd_next      = cmd_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        lvl_next      = lvl_reg;
        probes_next   = probes_reg;
        high_next     = high_reg;
        idx_next      = idx_reg;
        row_next      = row_reg;
        fresh_next    = fresh_reg;
        matched_next  = matched_reg;
        have_min_next = have_min_reg;
        min_lvl_next  = min_lvl_reg;
        min_idx_next  = min_idx_reg;
        min_lab_next  = min_lab_reg;
        min_cnt_next  = min_cnt_reg;
        est_next      = est_reg;
        fine_next     = fine_reg;
        rep_next      = rep_reg;
        sk_key_next   = sk_key_reg;
        sk_amt_next   = sk_amt_reg;
        sk_min_next   = sk_min_reg;
        best_next     = best_reg;
        bm_addr_next  = bm_addr_reg;
        bit_sel_next  = bit_sel_reg;
        cell_addr_next = cell_addr_reg;
        sk_addr_next  = sk_addr_reg;
        done_next     = 1'b0;

        hreq.start = 1'b0;
        hreq.key   = src_reg;
        hreq.seed  = seed_base_reg;

        bm_we       = 1'b0;
        bm_wa       = bm_addr_reg;
        bm_wd       = bm_rd_reg | bit_mask;
        cell_we_all = 1'b0;
        cell_we_cnt = 1'b0;
        cell_wa     = cell_addr_reg;
        cell_wd_lbl = src_reg;
        cell_wd_cnt = cnt_inc;
        cell_wd_lvl = lvl_reg;
        sk_we       = 1'b0;
        sk_wa       = sk_addr_reg;
        sk_wd       = sk_sat;

        unique case (state_reg)
            ST_CLEAR:
            begin
                bm_we       = 1'b1;
                bm_wa       = clr_cnt_reg[BM_AW-1:0];
                bm_wd       = '0;
                cell_we_all = 1'b1;
                cell_wa     = clr_cnt_reg[CELL_AW-1:0];
                cell_wd_lbl = '0;
                cell_wd_cnt = '0;
                cell_wd_lvl = '0;
                sk_we       = 1'b1;
                sk_wa       = clr_cnt_reg[SK_AW-1:0];
                sk_wd       = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd;
                    src_next      = source_label;
                    dst_next      = dest_label;
                    lvl_next      = level;
                    probes_next   = (level > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : level;
                    high_next     = (lvl_x4 > lc_x3);
                    idx_next      = '0;
                    fresh_next    = 1'b0;
                    matched_next  = 1'b0;
                    have_min_next = 1'b0;
                    est_next      = '0;
                    fine_next     = 1'b0;
                    rep_next      = 1'b0;
                    state_next    = (cmd == CMD_QUERY) ? ST_PTEST : ST_BHASH;
                end
            end
            ST_BHASH:
            begin
                hreq.start = 1'b1;
                hreq.key   = src_reg ^ dst_reg;
                hreq.seed  = seed_base_reg + 32'(idx_reg);
                state_next = ST_BWAIT;
            end
            ST_BWAIT:
            begin
                if (hdone)
                begin
                    bm_addr_next = hval[BM_IW-1:5];
                    bit_sel_next = hval[4:0];
                    state_next   = ST_BREAD;
                end
            end
            ST_BREAD:
            begin
                state_next = ST_BCHK;
            end
            ST_BCHK:
            begin
                if ((bm_rd_reg & bit_mask) == 32'd0)
                begin
                    bm_we      = 1'b1;
                    fresh_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 < LVL_W'(BITMAP_HASHES))
                    state_next = ST_BHASH;
                else if (fresh_next)
                begin
                    idx_next   = '0;
                    state_next = ST_PTEST;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PTEST:
            begin
                state_next = (idx_reg < probes_reg && !matched_reg) ? ST_PHASH : ST_PDEC;
            end
            ST_PHASH:
            begin
                hreq.start = 1'b1;
                hreq.key   = src_reg;
                hreq.seed  = seed_base_reg + CELL_SEED_OFS + 32'(idx_reg);
                state_next = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (hdone)
                begin
                    cell_addr_next = hval[CELL_AW-1:0];
                    state_next     = ST_PREAD;
                end
            end
            ST_PREAD:
            begin
                state_next = ST_PCHK;
            end
            ST_PCHK:
            begin
                if (cell_lbl_rd_reg == src_reg)
                begin
                    matched_next = 1'b1;
                    fine_next    = 1'b1;
                    if (cmd_reg == CMD_QUERY)
                        est_next = cell_cnt_rd_reg;
                    else
                    begin
                        cell_we_cnt = 1'b1;
                        est_next    = cnt_inc;
                        rep_next    = high_reg && (cnt_inc >= threshold_reg);
                    end
                end
                else if (!have_min_reg || cell_lvl_rd_reg < min_lvl_reg)
                begin
                    // first probed cell, or a lower level than the best so far
                    have_min_next = 1'b1;
                    min_lvl_next  = cell_lvl_rd_reg;
                    min_idx_next  = cell_addr_reg;
                    min_lab_next  = cell_lbl_rd_reg;
                    min_cnt_next  = cell_cnt_rd_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_PTEST;
            end
            ST_PDEC:
            begin
                row_next   = '0;
                state_next = ST_SHASH;
                if (matched_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cmd_reg == CMD_QUERY)
                begin
                    sk_min_next = 1'b1;
                    sk_key_next = src_reg;
                    best_next   = COUNT_MAX;
                end
                else if (have_min_reg && lvl_reg > min_lvl_reg)
                begin
                    // evict the lowest cell; its count moves to the sketch
                    cell_we_all = 1'b1;
                    cell_wa     = min_idx_reg;
                    cell_wd_cnt = CNT_W'(1);
                    est_next    = CNT_W'(1);
                    fine_next   = 1'b1;
                    rep_next    = high_reg && (threshold_reg <= CNT_W'(1));
                    sk_min_next = 1'b0;
                    sk_key_next = min_lab_reg;
                    sk_amt_next = min_cnt_reg;
                end
                else
                begin
                    sk_min_next = 1'b0;
                    sk_key_next = src_reg;
                    sk_amt_next = CNT_W'(1);
                end
            end
            ST_SHASH:
            begin
                hreq.start = 1'b1;
                hreq.key   = sk_key_reg;
                hreq.seed  = seed_base_reg + ROW_SEED_OFS + 32'(row_reg);
                state_next = ST_SWAIT;
            end
            ST_SWAIT:
            begin
                if (hdone)
                begin
                    sk_addr_next = {row_reg[SK_RW-1:0], hval[SK_CW-1:0]};
                    state_next   = ST_SREAD;
                end
            end
            ST_SREAD:
            begin
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (sk_min_reg)
                begin
                    if (sk_rd_reg < best_reg)
                        best_next = sk_rd_reg;
                end
                else
                    sk_we = 1'b1;
                row_next = row_reg + 1'b1;
                if (row_reg + 1'b1 < ROWC_W'(SKETCH_ROWS))
                    state_next = ST_SHASH;
                else
                begin
                    if (sk_min_reg)
                        est_next = best_next;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            done_reg     <= 1'b0;
            fresh_reg    <= 1'b0;
            fine_reg     <= 1'b0;
            rep_reg      <= 1'b0;
            matched_reg  <= 1'b0;
            have_min_reg <= 1'b0;
            sk_min_reg   <= 1'b0;
            idx_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            done_reg     <= done_next;
            fresh_reg    <= fresh_next;
            fine_reg     <= fine_next;
            rep_reg      <= rep_next;
            matched_reg  <= matched_next;
            have_min_reg <= have_min_next;
            sk_min_reg   <= sk_min_next;
            idx_reg      <= idx_next;
            row_reg      <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        lvl_reg       <= lvl_next;
        probes_reg    <= probes_next;
        high_reg      <= high_next;
        min_lvl_reg   <= min_lvl_next;
        min_idx_reg   <= min_idx_next;
        min_lab_reg   <= min_lab_next;
        min_cnt_reg   <= min_cnt_next;
        est_reg       <= est_next;
        sk_key_reg    <= sk_key_next;
        sk_amt_reg    <= sk_amt_next;
        best_reg      <= best_next;
        bm_addr_reg   <= bm_addr_next;
        bit_sel_reg   <= bit_sel_next;
        cell_addr_reg <= cell_addr_next;
        sk_addr_reg   <= sk_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bm_mem[bm_wa] <= bm_wd;
        bm_rd_reg <= bm_mem[bm_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cell_we_all)
        begin
            cell_lbl_mem[cell_wa] <= cell_wd_lbl;
            cell_lvl_mem[cell_wa] <= cell_wd_lvl;
        end
        if (cell_we_all || cell_we_cnt)
            cell_cnt_mem[cell_wa] <= cell_wd_cnt;
        cell_lbl_rd_reg <= cell_lbl_mem[cell_addr_reg];
        cell_cnt_rd_reg <= cell_cnt_mem[cell_addr_reg];
        cell_lvl_rd_reg <= cell_lvl_mem[cell_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
            sk_mem[sk_wa] <= sk_wd;
        sk_rd_reg <= sk_mem[sk_addr_reg];
    end

    a_done_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_BCHK || $past(state_reg) == ST_PDEC
                  || $past(state_reg) == ST_SCHK))
        else $error("result strobe without a finishing step");

    a_hash_waited: assert property (@(posedge clk) disable iff (!rst_n)
        hdone |-> (state_reg == ST_BWAIT || state_reg == ST_PWAIT || state_reg == ST_SWAIT))
        else $error("hash finished while the sequencer was not waiting");

    a_report_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (done && report) |-> (in_fine_part && new_pair))
        else $error("report raised for a source outside the cells");

endmodule
